// File: hw/rtl/gfpr_pkg.sv
// Shared types, codes and constants of the gap-framed packet receiver.
package gfpr_pkg;

   localparam int FRAME_LEN_DEFAULT = 6;
   localparam int CHECK_BYTES = 5;        // sync, address, command, payload, checksum
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [3:0] GAP_MAX = 4'd15;
   localparam logic [3:0] GAP_RESTART_LO = 4'd3;
   localparam logic [3:0] GAP_LIMIT = 4'd4;
   localparam logic [7:0] ADDR_LIMIT = 8'hFD;

   localparam logic OP_BYTE = 1'b0;
   localparam logic OP_TICK = 1'b1;

   localparam logic [7:0] SYNC_RESET = 8'hFF;
   localparam logic [7:0] PLAY_RESET = 8'd1;
   localparam logic [7:0] STOP_RESET = 8'd2;
   localparam logic [7:0] LEARN_RESET = 8'd3;

   typedef enum logic [1:0] {
      REG_SYNC  = 2'd0,
      REG_PLAY  = 2'd1,
      REG_STOP  = 2'd2,
      REG_LEARN = 2'd3
   } reg_index_type;

   typedef enum logic [2:0] {
      STATUS_OK       = 3'd0,
      STATUS_SYNC_ERR = 3'd1,
      STATUS_ADDR_ERR = 3'd2,
      STATUS_CSUM_ERR = 3'd3,
      STATUS_UNK_CMD  = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      KIND_PLAY  = 2'd0,
      KIND_STOP  = 2'd1,
      KIND_LEARN = 2'd2,
      KIND_NONE  = 2'd3
   } kind_type;

   typedef struct packed {
      logic [7:0] sync_value;
      logic [7:0] play_code;
      logic [7:0] stop_code;
      logic [7:0] learn_code;
   } cfg_type;

   typedef struct packed {
      status_type status;
      logic [7:0] address;
      logic [7:0] command;
      logic [7:0] payload;
      kind_type   command_kind;
   } rsp_type;

endpackage

// File: hw/rtl/gfpr_csr.sv
// APB-style configuration registers of the packet receiver.
module gfpr_csr
   import gfpr_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type       cfg_ff, cfg_in;
   reg_index_type index;
   logic          wr_en;

   assign pready = 1'b1;
   assign index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign wr_en = psel & penable & pwrite;
   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (index)
            REG_SYNC:  cfg_in.sync_value = pwdata[7:0];
            REG_PLAY:  cfg_in.play_code = pwdata[7:0];
            REG_STOP:  cfg_in.stop_code = pwdata[7:0];
            REG_LEARN: cfg_in.learn_code = pwdata[7:0];
            default:   cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (index)
         REG_SYNC:  prdata = {24'd0, cfg_ff.sync_value};
         REG_PLAY:  prdata = {24'd0, cfg_ff.play_code};
         REG_STOP:  prdata = {24'd0, cfg_ff.stop_code};
         REG_LEARN: prdata = {24'd0, cfg_ff.learn_code};
         default:   prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.sync_value <= SYNC_RESET;
         cfg_ff.play_code <= PLAY_RESET;
         cfg_ff.stop_code <= STOP_RESET;
         cfg_ff.learn_code <= LEARN_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: hw/rtl/gfpr_frame.sv
// Gap timer, frame store and frame check of the packet receiver.
module gfpr_frame
   import gfpr_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       fire,
   input  logic       operation,
   input  logic [7:0] rx_byte,
   output logic       rsp_push,
   output rsp_type    rsp_data
);

   localparam int IDX_W = $clog2(FRAME_LEN);
   localparam logic [3:0] LEN4 = 4'(FRAME_LEN);

   logic [7:0] store_ff [FRAME_LEN];
   logic [3:0] wp_ff, wp_in;
   logic [3:0] gap_ff, gap_in;
   logic       timer_ff, timer_in;

   logic       is_byte;
   logic       restart;
   logic [3:0] idx;
   logic [3:0] wp_inc;
   logic [3:0] gap_sat;
   logic [7:0] view [CHECK_BYTES];
   logic [7:0] sum;
   logic [7:0] csum;

   // sum mod 100 as two BCD digits; tens by multiply-shift (exact for 0..99)
   function automatic logic [7:0] bcd_mod100(input logic [7:0] s);
      logic [6:0]  r;
      logic [14:0] prod;
      logic [3:0]  tens;
      logic [6:0]  units;
      if (s >= 8'd200) begin
         r = 7'(s - 8'd200);
      end else if (s >= 8'd100) begin
         r = 7'(s - 8'd100);
      end else begin
         r = s[6:0];
      end
      prod = 15'(r) * 15'd205;
      tens = prod[14:11];
      units = r - 7'(tens) * 7'd10;
      return {tens, units[3:0]};
   endfunction

   assign is_byte = fire && (operation == OP_BYTE);
   assign restart = (gap_ff >= GAP_RESTART_LO) && (gap_ff <= GAP_LIMIT);
   assign idx = restart ? 4'd0 : wp_ff;
   assign wp_inc = idx + 4'd1;
   assign gap_sat = (gap_ff == GAP_MAX) ? GAP_MAX : gap_ff + 4'd1;

   // bypass the byte being written so a frame ending on a check byte sees it
   always_comb begin
      for (int k = 0; k < CHECK_BYTES; k++) begin
         view[k] = (idx == 4'(k)) ? rx_byte : store_ff[k];
      end
   end

   always_comb begin
      wp_in = wp_ff;
      gap_in = gap_ff;
      timer_in = timer_ff;
      if (fire) begin
         if (operation == OP_TICK) begin
            if (timer_ff) begin
               gap_in = gap_sat;
               if ((gap_sat > GAP_LIMIT) && (wp_ff != 4'd0)) begin
                  timer_in = 1'b0;
                  wp_in = 4'd0;
               end
            end
         end else begin
            gap_in = 4'd0;
            timer_in = 1'b1;
            wp_in = (wp_inc == LEN4) ? 4'd0 : wp_inc;
         end
      end
   end

   assign sum = view[1] + view[2] + view[3];
   assign csum = bcd_mod100(sum);

   always_comb begin
      rsp_data.status = STATUS_OK;
      rsp_data.command_kind = KIND_NONE;
      rsp_data.address = view[1];
      rsp_data.command = view[2];
      rsp_data.payload = view[3];
      if (view[0] != cfg.sync_value) begin
         rsp_data.status = STATUS_SYNC_ERR;
      end else if (view[1] >= ADDR_LIMIT) begin
         rsp_data.status = STATUS_ADDR_ERR;
      end else if (csum != view[4]) begin
         rsp_data.status = STATUS_CSUM_ERR;
      end else if (view[2] == cfg.play_code) begin
         rsp_data.command_kind = KIND_PLAY;
      end else if (view[2] == cfg.stop_code) begin
         rsp_data.command_kind = KIND_STOP;
      end else if (view[2] == cfg.learn_code) begin
         rsp_data.command_kind = KIND_LEARN;
      end else begin
         rsp_data.status = STATUS_UNK_CMD;
      end
   end

   assign rsp_push = is_byte && (wp_inc == LEN4);

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 4'd0;
         gap_ff <= 4'd0;
         timer_ff <= 1'b0;
      end else begin
         wp_ff <= wp_in;
         gap_ff <= gap_in;
         timer_ff <= timer_in;
      end
   end

   // write position always stays below FRAME_LEN
   always_ff @(posedge clock) begin
      if (is_byte) begin
         store_ff[idx[IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

// File: hw/rtl/gfpr_rsp_buf.sv
// Two-entry result buffer: output register plus skid slot.
module gfpr_rsp_buf
   import gfpr_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   output logic    space,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   rsp_type    head_ff, head_in;
   rsp_type    spare_ff, spare_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign space = (count_ff != 2'd2);
   assign pop = rsp_valid & rsp_ready;
   assign rsp_data = head_ff;

   always_comb begin
      head_in = head_ff;
      spare_in = spare_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
      case (count_ff)
         2'd0: begin
            if (push) head_in = push_data;
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               spare_in = push_data;
            end
         end
         2'd2: begin
            if (pop) head_in = spare_ff;
         end
         default: count_in = 2'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      spare_ff <= spare_in;
   end

endmodule

// File: hw/rtl/gap_framed_packet_receiver.sv
// Top level of the gap-framed packet receiver.
// Takes one transfer per cycle while req_ready is high, either a received byte or a character-time tick.
// Ticks advance a gap counter while the gap timer runs; a byte after a gap of
// 3 or 4 ticks restarts the frame, and more than 4 ticks drop a partial frame.
// Every FRAME_LEN-th byte of a frame produces one result transfer, checked for
// sync, address, BCD checksum and command code in that order. Each transfer is
// handled by the gap and frame logic, and the result lands in a two-entry output
// buffer in the cycle after the closing byte is taken; req_ready drops
// only while both buffer entries hold untaken results.
module gap_framed_packet_receiver
   import gfpr_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_operation,
   input  logic [7:0]            req_rx_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [2:0]            rsp_status,
   output logic [7:0]            rsp_address,
   output logic [7:0]            rsp_command,
   output logic [7:0]            rsp_payload,
   output logic [1:0]            rsp_command_kind,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;
   rsp_type frame_rsp;
   rsp_type out_rsp;
   logic    frame_push;
   logic    space;
   logic    fire;

   assign req_ready = space;
   assign fire = req_valid & space;

   gfpr_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   gfpr_frame #(
      .FRAME_LEN (FRAME_LEN)
   ) u_frame (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (fire),
      .operation (req_operation),
      .rx_byte   (req_rx_byte),
      .rsp_push  (frame_push),
      .rsp_data  (frame_rsp)
   );

   gfpr_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (frame_push),
      .push_data (frame_rsp),
      .space     (space),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (out_rsp)
   );

   assign rsp_status = out_rsp.status;
   assign rsp_address = out_rsp.address;
   assign rsp_command = out_rsp.command;
   assign rsp_payload = out_rsp.payload;
   assign rsp_command_kind = out_rsp.command_kind;

endmodule

// File: test/gfpr_frame_checker.sv
// Watches the gap-framed packet receiver's ports, predicts each frame result and compares it.
module gfpr_frame_checker
   import gfpr_pkg::*;
#(
   parameter int FRAME_LEN = FRAME_LEN_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_ready,
   input  logic                  req_operation,
   input  logic [7:0]            req_rx_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_ready,
   input  logic [2:0]            rsp_status,
   input  logic [7:0]            rsp_address,
   input  logic [7:0]            rsp_command,
   input  logic [7:0]            rsp_payload,
   input  logic [1:0]            rsp_command_kind,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    fail_count,
   output int                    outstanding,
   output int                    frames_checked
);
   timeunit 1ns;
   timeprecision 1ps;

   cfg_type     codes;
   logic [7:0]  frame_bytes [16];
   logic [3:0]  wr_pos;
   logic [3:0]  gap_ticks;
   logic        gap_running;
   rsp_type     frames_due [$];
   rsp_type     due;
   int          fails;
   int          checked;

   function automatic rsp_type judge_frame();
      rsp_type    res;
      logic [7:0] sum;
      int         rem;
      logic [7:0] bcd;
      sum = frame_bytes[1] + frame_bytes[2] + frame_bytes[3];
      rem = int'(sum) % 100;
      bcd = 8'((rem / 10) * 16 + rem % 10);
      res.status = STATUS_OK;
      res.command_kind = KIND_NONE;
      res.address = frame_bytes[1];
      res.command = frame_bytes[2];
      res.payload = frame_bytes[3];
      if (frame_bytes[0] != codes.sync_value) res.status = STATUS_SYNC_ERR;
      else if (frame_bytes[1] >= ADDR_LIMIT) res.status = STATUS_ADDR_ERR;
      else if (frame_bytes[4] != bcd) res.status = STATUS_CSUM_ERR;
      else if (frame_bytes[2] == codes.play_code) res.command_kind = KIND_PLAY;
      else if (frame_bytes[2] == codes.stop_code) res.command_kind = KIND_STOP;
      else if (frame_bytes[2] == codes.learn_code) res.command_kind = KIND_LEARN;
      else res.status = STATUS_UNK_CMD;
      return res;
   endfunction

   task automatic take_transfer(input logic op, input logic [7:0] rx);
      if (op == OP_TICK) begin
         if (gap_running) begin
            if (gap_ticks < GAP_MAX) gap_ticks++;
            // idle timeout drops a partial frame only
            if (gap_ticks > GAP_LIMIT && wr_pos != 4'd0) begin
               gap_running = 1'b0;
               wr_pos = 4'd0;
            end
         end
      end else begin
         if (gap_ticks >= GAP_RESTART_LO && gap_ticks <= GAP_LIMIT) wr_pos = 4'd0;
         gap_ticks = 4'd0;
         gap_running = 1'b1;
         frame_bytes[wr_pos] = rx;
         wr_pos = wr_pos + 4'd1;
         if (wr_pos >= FRAME_LEN) begin
            wr_pos = 4'd0;
            frames_due.push_back(judge_frame());
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         codes = '{SYNC_RESET, PLAY_RESET, STOP_RESET, LEARN_RESET};
         wr_pos = 4'd0;
         gap_ticks = 4'd0;
         gap_running = 1'b0;
         frames_due.delete();
         fails = 0;
         checked = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (frames_due.size() == 0) begin
               $error("result transfer with no frame pending: status %0d address %0h",
                      rsp_status, rsp_address);
               fails++;
            end else begin
               due = frames_due.pop_front();
               checked++;
               if (rsp_status != due.status) begin
                  $error("status: expected %0d, got %0d", due.status, rsp_status);
                  fails++;
               end
               if (rsp_address != due.address) begin
                  $error("address: expected %0h, got %0h", due.address, rsp_address);
                  fails++;
               end
               if (rsp_command != due.command) begin
                  $error("command: expected %0h, got %0h", due.command, rsp_command);
                  fails++;
               end
               if (rsp_payload != due.payload) begin
                  $error("payload: expected %0h, got %0h", due.payload, rsp_payload);
                  fails++;
               end
               if (rsp_command_kind != due.command_kind) begin
                  $error("command_kind: expected %0d, got %0d",
                         due.command_kind, rsp_command_kind);
                  fails++;
               end
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (reg_index_type'(csr_paddr[3:2]))
               REG_SYNC:  codes.sync_value = csr_pwdata[7:0];
               REG_PLAY:  codes.play_code = csr_pwdata[7:0];
               REG_STOP:  codes.stop_code = csr_pwdata[7:0];
               REG_LEARN: codes.learn_code = csr_pwdata[7:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) take_transfer(req_operation, req_rx_byte);
      end
      fail_count <= fails;
      outstanding <= frames_due.size();
      frames_checked <= checked;
   end

endmodule

// File: test/tb_gap_framed_packet_receiver.sv
// Stimulus and verdict for the gap-framed packet receiver.
module tb_gap_framed_packet_receiver;
   import gfpr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 200000;
   localparam int HOLD_CYCLES = 300;
   localparam int PHASE_ITEMS = 160;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   logic                  req_operation = OP_TICK;
   logic [7:0]            req_rx_byte = 8'd0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [2:0]            rsp_status;
   logic [7:0]            rsp_address;
   logic [7:0]            rsp_command;
   logic [7:0]            rsp_payload;
   logic [1:0]            rsp_command_kind;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;
   int                    fail_count;
   int                    outstanding;
   int                    frames_checked;

   cfg_type cur_cfg;
   int      send_idle_pct = 20;
   int      sink_idle_pct = 20;
   int      hold_asked = 0;
   int      hold_served = 0;
   int      hold_left = 0;
   int      sent = 0;
   int      settings = 0;
   int      phase_start;

   gap_framed_packet_receiver #(.FRAME_LEN(FRAME_LEN_DEFAULT)) u_dut (.*);
   gfpr_frame_checker #(.FRAME_LEN(FRAME_LEN_DEFAULT)) u_checker (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // result side: random stalls, plus a long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= sink_idle_pct);
         end
      end
   end

   task automatic send_item(input logic op, input logic [7:0] rx);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_rx_byte <= rx;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent++;
   endtask

   task automatic send_ticks(input int n);
      repeat (n) send_item(OP_TICK, 8'($urandom()));
   endtask

   task automatic send_raw(input logic [47:0] fb);
      for (int i = 0; i < 6; i++) send_item(OP_BYTE, fb[47-8*i -: 8]);
   endtask

   // mostly well-formed frames; some faults, in-frame ticks and broken gaps
   task automatic send_frame();
      logic [7:0] fb [6];
      logic [7:0] sum;
      int         fault;
      int         pick;
      int         rem;
      int         roll;
      fault = $urandom_range(0, 9);
      pick = $urandom_range(0, 3);
      fb[0] = cur_cfg.sync_value;
      fb[1] = 8'($urandom_range(0, 252));
      fb[2] = (pick == 0) ? cur_cfg.play_code :
              (pick == 1) ? cur_cfg.stop_code :
              (pick == 2) ? cur_cfg.learn_code : 8'($urandom());
      fb[3] = 8'($urandom());
      fb[5] = 8'($urandom());
      if (fault == 0) fb[0] = fb[0] ^ 8'(1 << $urandom_range(0, 7));
      if (fault == 1) fb[1] = 8'($urandom_range(253, 255));
      if (fault == 3) fb[2] = 8'($urandom());
      sum = fb[1] + fb[2] + fb[3];
      rem = int'(sum) % 100;
      fb[4] = 8'((rem / 10) * 16 + rem % 10);
      if (fault == 2) fb[4] = fb[4] ^ 8'(1 << $urandom_range(0, 7));
      // at least three ticks realign the frame; a long run saturates the gap
      if ($urandom_range(0, 99) < 5) send_ticks($urandom_range(14, 20));
      else send_ticks($urandom_range(3, 6));
      for (int i = 0; i < 6; i++) begin
         if (i > 0) begin
            roll = $urandom_range(0, 99);
            if (roll < 8) send_ticks($urandom_range(1, 2));
            else if (roll < 10) send_ticks($urandom_range(3, 8));
         end
         send_item(OP_BYTE, fb[i]);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [7:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic program_codes(input cfg_type c);
      csr_write(REG_SYNC, c.sync_value);
      csr_write(REG_PLAY, c.play_code);
      csr_write(REG_STOP, c.stop_code);
      csr_write(REG_LEARN, c.learn_code);
      cur_cfg = c;
      settings++;
   endtask

   initial begin
      cfg_type phase_cfg [5];
      int      roll;
      cur_cfg = '{SYNC_RESET, PLAY_RESET, STOP_RESET, LEARN_RESET};
      phase_cfg[0] = '{8'h00, 8'hFF, 8'h00, 8'h80};
      phase_cfg[1] = '{8'hFF, 8'h55, 8'h55, 8'h55};  // play wins all overlaps
      phase_cfg[2] = '{8'hA5, 8'h10, 8'h20, 8'h20};  // stop wins over learn
      phase_cfg[3] = '{8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom())};
      phase_cfg[4] = '{8'($urandom()), 8'($urandom()), 8'($urandom()), 8'($urandom())};
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed, reset codes
      send_ticks(1);                        // timer still stopped
      send_raw(48'hFF_FC_01_FF_52_00);      // play, top good address, sum wraps
      send_ticks(3);
      send_raw(48'hFF_FD_03_00_00_00);      // lowest bad address
      send_ticks(4);
      send_raw(48'h00_00_00_00_00_FF);      // sync mismatch
      send_item(OP_BYTE, 8'hFF);
      send_item(OP_BYTE, 8'h10);
      send_ticks(5);                        // partial frame times out
      send_raw(48'hFF_01_03_02_06_77);      // learn
      settings++;

      for (int ph = 0; ph < 5; ph++) begin
         wait_drained();
         program_codes(phase_cfg[ph]);
         send_idle_pct = (ph == 2) ? 0 : 20;
         sink_idle_pct <= (ph == 2) ? 0 : 20;
         if (ph == 1) hold_asked <= hold_asked + 1;
         phase_start = sent;
         while (sent - phase_start < PHASE_ITEMS) begin
            roll = $urandom_range(0, 99);
            if (roll < 12) send_item(logic'($urandom_range(0, 1)), 8'($urandom()));
            else send_frame();
         end
      end

      send_idle_pct = 20;
      wait_drained();
      repeat (10) @(posedge clock);
      $display("Run covered %0d transfers and %0d frame results under %0d code settings,",
               sent, frames_checked, settings);
      $display("with gap restarts, timeouts, saturation and a %0d-cycle result stall.",
               HOLD_CYCLES);
      if (fail_count == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
